FILE: src/ahsv_pkg.sv
// ----------------------------------------------------------------------------
// ahsv_pkg
// Shared types and constants of the harmonic sine voice: envelope stages,
// register map, register reset values and the configuration bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ahsv_pkg;

   localparam int PHASE_BITS_DEFAULT     = 32;
   localparam int SINE_ADDR_BITS_DEFAULT = 10;

   localparam int ENV_BITS    = 25;
   localparam int STAGE_BITS  = 3;
   localparam int STEP_BITS   = 31;
   localparam int SAMPLE_BITS = 16;

   // An item in the queue carries the phase plus level, stage and block mark.
   localparam int ENTRY_EXTRA_BITS = ENV_BITS + STAGE_BITS + 1;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [ENV_BITS-1:0] FULL_SCALE = 25'd16777216;

   localparam logic [16:0]         OUTPUT_GAIN_RESET    = 17'd65536;
   localparam logic [15:0]         HARMONIC2_GAIN_RESET = 16'd0;
   localparam logic [15:0]         HARMONIC3_GAIN_RESET = 16'd0;
   localparam logic [ENV_BITS-1:0] ATTACK_STEP_RESET    = 25'd16777;
   localparam logic [ENV_BITS-1:0] DECAY_STEP_RESET     = 25'd16777;
   localparam logic [ENV_BITS-1:0] SUSTAIN_LEVEL_RESET  = 25'd11744051;
   localparam logic [ENV_BITS-1:0] RELEASE_STEP_RESET   = 25'd16777;
   localparam logic [ENV_BITS-1:0] FADE_STEP_RESET      = 25'd33554;

   typedef enum logic [2:0] {
      REG_OUTPUT_GAIN    = 3'd0,
      REG_HARMONIC2_GAIN = 3'd1,
      REG_HARMONIC3_GAIN = 3'd2,
      REG_ATTACK_STEP    = 3'd3,
      REG_DECAY_STEP     = 3'd4,
      REG_SUSTAIN_LEVEL  = 3'd5,
      REG_RELEASE_STEP   = 3'd6,
      REG_FADE_STEP      = 3'd7
   } reg_index_type;

   typedef enum logic [STAGE_BITS-1:0] {
      STAGE_IDLE    = 3'd0,
      STAGE_ATTACK  = 3'd1,
      STAGE_DECAY   = 3'd2,
      STAGE_SUSTAIN = 3'd3,
      STAGE_RELEASE = 3'd4,
      STAGE_FADE    = 3'd5
   } stage_type;

   typedef struct packed {
      logic [ENV_BITS-1:0] attack_step;
      logic [ENV_BITS-1:0] decay_step;
      logic [ENV_BITS-1:0] sustain_level;
      logic [ENV_BITS-1:0] release_step;
      logic [ENV_BITS-1:0] fade_step;
   } env_cfg_type;

   typedef struct packed {
      logic [16:0] output_gain;
      logic [15:0] harmonic2_gain;
      logic [15:0] harmonic3_gain;
   } mix_cfg_type;

endpackage

`default_nettype wire

FILE: src/ahsv_front.sv
// ----------------------------------------------------------------------------
// ahsv_front
// Accepts sample ticks, runs the envelope state machine and the phase
// accumulator, and pushes one work entry per tick into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsv_front #(
   parameter int PHASE_BITS = ahsv_pkg::PHASE_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_note_on,
   input  wire logic                                  req_fade_start,
   input  wire logic [ahsv_pkg::STEP_BITS-1:0]        req_phase_step,
   input  wire logic                                  req_block_end,
   input  wire ahsv_pkg::env_cfg_type                 env_cfg,
   input  wire logic                                  queue_full,
   output logic                                       push,
   output logic [PHASE_BITS+ahsv_pkg::ENTRY_EXTRA_BITS-1:0] push_data
);

   localparam int SUM_BITS = PHASE_BITS + ahsv_pkg::STEP_BITS;

   logic [PHASE_BITS-1:0]             phase_ff;
   logic [PHASE_BITS-1:0]             phase_in;
   logic [ahsv_pkg::ENV_BITS-1:0]     level_ff;
   logic [ahsv_pkg::ENV_BITS-1:0]     level_in;
   ahsv_pkg::stage_type               stage_ff;
   ahsv_pkg::stage_type               stage_in;

   ahsv_pkg::stage_type               stage_start;
   ahsv_pkg::stage_type               stage_eff;
   logic [ahsv_pkg::ENV_BITS-1:0]     fall_step;
   logic [ahsv_pkg::ENV_BITS-1:0]     fall_floor;
   logic signed [ahsv_pkg::ENV_BITS+1:0] fall_diff;
   logic                              at_floor;
   logic [ahsv_pkg::ENV_BITS:0]       rise;
   logic                              rise_full;
   logic [SUM_BITS-1:0]               phase_sum;
   logic                              accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   assign stage_start = req_fade_start ? ahsv_pkg::STAGE_FADE : stage_ff;

   always_comb begin
      if (stage_start == ahsv_pkg::STAGE_FADE) begin
         stage_eff = ahsv_pkg::STAGE_FADE;
      end else if (req_note_on && stage_start == ahsv_pkg::STAGE_IDLE) begin
         stage_eff = ahsv_pkg::STAGE_ATTACK;
      end else if (!req_note_on && stage_start != ahsv_pkg::STAGE_IDLE &&
                   stage_start != ahsv_pkg::STAGE_RELEASE) begin
         stage_eff = ahsv_pkg::STAGE_RELEASE;
      end else begin
         stage_eff = stage_start;
      end
   end

   always_comb begin
      case (stage_eff)
         ahsv_pkg::STAGE_FADE: begin
            fall_step  = env_cfg.fade_step;
            fall_floor = '0;
         end
         ahsv_pkg::STAGE_DECAY: begin
            fall_step  = env_cfg.decay_step;
            fall_floor = env_cfg.sustain_level;
         end
         default: begin
            fall_step  = env_cfg.release_step;
            fall_floor = '0;
         end
      endcase
   end

   assign fall_diff = $signed({2'b00, level_ff}) - $signed({2'b00, fall_step});
   assign at_floor  = fall_diff <= $signed({2'b00, fall_floor});
   assign rise      = {1'b0, level_ff} + {1'b0, env_cfg.attack_step};
   assign rise_full = rise >= {1'b0, ahsv_pkg::FULL_SCALE};

   always_comb begin
      case (stage_eff)
         ahsv_pkg::STAGE_FADE:    stage_in = at_floor ? ahsv_pkg::STAGE_IDLE
                                                      : ahsv_pkg::STAGE_FADE;
         ahsv_pkg::STAGE_ATTACK:  stage_in = rise_full ? ahsv_pkg::STAGE_DECAY
                                                       : ahsv_pkg::STAGE_ATTACK;
         ahsv_pkg::STAGE_DECAY:   stage_in = at_floor ? ahsv_pkg::STAGE_SUSTAIN
                                                      : ahsv_pkg::STAGE_DECAY;
         ahsv_pkg::STAGE_SUSTAIN: stage_in = ahsv_pkg::STAGE_SUSTAIN;
         ahsv_pkg::STAGE_RELEASE: stage_in = at_floor ? ahsv_pkg::STAGE_IDLE
                                                      : ahsv_pkg::STAGE_RELEASE;
         default:                 stage_in = ahsv_pkg::STAGE_IDLE;
      endcase
   end

   always_comb begin
      case (stage_eff)
         ahsv_pkg::STAGE_FADE,
         ahsv_pkg::STAGE_DECAY,
         ahsv_pkg::STAGE_RELEASE: begin
            level_in = at_floor ? fall_floor : fall_diff[ahsv_pkg::ENV_BITS-1:0];
         end
         ahsv_pkg::STAGE_ATTACK: begin
            level_in = rise_full ? ahsv_pkg::FULL_SCALE : rise[ahsv_pkg::ENV_BITS-1:0];
         end
         ahsv_pkg::STAGE_SUSTAIN: begin
            level_in = env_cfg.sustain_level;
         end
         default: begin
            level_in = level_ff;
         end
      endcase
   end

   assign phase_sum = {{ahsv_pkg::STEP_BITS{1'b0}}, phase_ff} +
                      {{PHASE_BITS{1'b0}}, req_phase_step};
   assign phase_in  = phase_sum[PHASE_BITS-1:0];

   assign push_data = {phase_ff, level_in, stage_in, req_block_end};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         level_ff <= '0;
         stage_ff <= ahsv_pkg::STAGE_IDLE;
      end else if (accept) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         stage_ff <= stage_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/ahsv_queue.sv
// ----------------------------------------------------------------------------
// ahsv_queue
// Small first-in first-out queue that decouples envelope control from the
// sample datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsv_queue #(
   parameter int ENTRY_BITS = ahsv_pkg::PHASE_BITS_DEFAULT + ahsv_pkg::ENTRY_EXTRA_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [ENTRY_BITS-1:0] push_data,
   output logic                       full,
   input  wire logic                  pop,
   output logic [ENTRY_BITS-1:0]      head_data,
   output logic                       empty
);

   logic [ENTRY_BITS-1:0]               entry_ff [ahsv_pkg::QUEUE_DEPTH];
   logic [ahsv_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [ahsv_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [ahsv_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [ahsv_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [ahsv_pkg::QUEUE_PTR_BITS:0]   count_ff;
   logic [ahsv_pkg::QUEUE_PTR_BITS:0]   count_in;
   logic                                do_push;
   logic                                do_pop;

   assign full      = count_ff == (ahsv_pkg::QUEUE_PTR_BITS + 1)'(ahsv_pkg::QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/ahsv_sine_rom.sv
// ----------------------------------------------------------------------------
// ahsv_sine_rom
// Full-wave Q15 sine table with a registered read port. The contents are
// built at elaboration from a quarter wave evaluated by a Taylor series.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsv_sine_rom #(
   parameter int SINE_ADDR_BITS = ahsv_pkg::SINE_ADDR_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               enable,
   input  wire logic [SINE_ADDR_BITS-1:0]          addr,
   output logic signed [ahsv_pkg::SAMPLE_BITS-1:0] data
);

   localparam int DEPTH = 2 ** SINE_ADDR_BITS;
   localparam int QSIZE = 2 ** (SINE_ADDR_BITS - 2);
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   typedef logic signed [ahsv_pkg::SAMPLE_BITS-1:0] wave_type [DEPTH];

   function automatic logic [ahsv_pkg::SAMPLE_BITS-1:0] quarter_sine(input logic [63:0] q);
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] t;
      logic [63:0] r;
      logic [63:0] v;
      x = (q * HALF_PI_Q30 + ((64'd1 << (SINE_ADDR_BITS - 2)) >> 1)) >> (SINE_ADDR_BITS - 2);
      s = (x * x) >> 30;
      t = ONE_Q30 - s / 64'd72;
      t = ONE_Q30 - ((s * t) >> 30) / 64'd42;
      t = ONE_Q30 - ((s * t) >> 30) / 64'd20;
      t = ONE_Q30 - ((s * t) >> 30) / 64'd6;
      r = (x * t) >> 30;
      v = (r * 64'd32767 + (64'd1 << 29)) >> 30;
      return v[ahsv_pkg::SAMPLE_BITS-1:0];
   endfunction

   function automatic wave_type build_wave();
      wave_type                           w;
      logic [63:0]                        quad;
      logic [63:0]                        rem;
      logic [ahsv_pkg::SAMPLE_BITS-1:0]   v;
      for (int i = 0; i < DEPTH; i++) begin
         quad = (64'(i) >> (SINE_ADDR_BITS - 2)) & 64'd3;
         rem  = 64'(i) & 64'(QSIZE - 1);
         v    = quad[0] ? quarter_sine(64'(QSIZE) - rem) : quarter_sine(rem);
         w[i] = quad[1] ? -v : v;
      end
      return w;
   endfunction

   localparam wave_type WAVE = build_wave();

   logic signed [ahsv_pkg::SAMPLE_BITS-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= WAVE[addr];
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

FILE: src/ahsv_back.sv
// ----------------------------------------------------------------------------
// ahsv_back
// Sample datapath: three sine lookups, harmonic mix, output gain, envelope
// scaling and saturation, followed by the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsv_back #(
   parameter int PHASE_BITS     = ahsv_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_ADDR_BITS = ahsv_pkg::SINE_ADDR_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [PHASE_BITS+ahsv_pkg::ENTRY_EXTRA_BITS-1:0] head_data,
   input  wire logic                                  empty,
   output logic                                       pop,
   input  wire ahsv_pkg::mix_cfg_type                 mix_cfg,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [ahsv_pkg::SAMPLE_BITS-1:0]    rsp_sample_out,
   output logic [ahsv_pkg::ENV_BITS-1:0]              rsp_envelope_level,
   output logic [ahsv_pkg::STAGE_BITS-1:0]            rsp_stage_now,
   output logic                                       rsp_block_last
);

   localparam int ENV  = ahsv_pkg::ENV_BITS;
   localparam int SB   = ahsv_pkg::STAGE_BITS;
   localparam int SMP  = ahsv_pkg::SAMPLE_BITS;
   localparam int ENTRY_BITS = PHASE_BITS + ahsv_pkg::ENTRY_EXTRA_BITS;

   typedef struct packed {
      logic           valid;
      logic [ENV-1:0] level;
      logic [SB-1:0]  stage;
      logic           last;
   } tag_type;

   logic                    adv;
   logic [PHASE_BITS-1:0]   phase1;
   logic [PHASE_BITS-1:0]   phase2;
   logic [PHASE_BITS-1:0]   phase3;
   tag_type                 tag_head;

   logic signed [SMP-1:0]   sine1;
   logic signed [SMP-1:0]   sine2;
   logic signed [SMP-1:0]   sine3;

   tag_type                 tag_b_ff;
   tag_type                 tag_c_ff;
   tag_type                 tag_d_ff;
   tag_type                 tag_e_ff;

   logic signed [SMP-1:0]   sine1_c_ff;
   logic signed [SMP-1:0]   sine1_c_in;
   logic signed [32:0]      prod2_c_ff;
   logic signed [32:0]      prod2_c_in;
   logic signed [32:0]      prod3_c_ff;
   logic signed [32:0]      prod3_c_in;

   logic signed [33:0]      mix_sum;
   logic [33:0]             mix_neg;
   logic [32:0]             mag_d_ff;
   logic [32:0]             mag_d_in;
   logic                    neg_d_ff;
   logic                    neg_d_in;

   logic [49:0]             gain_prod;
   logic [49:0]             gain_round;
   logic [33:0]             gmag_e_ff;
   logic [33:0]             gmag_e_in;
   logic                    neg_e_ff;

   logic [59:0]             env_prod;
   logic [59:0]             env_round;
   logic [20:0]             final_mag;
   logic signed [SMP-1:0]   sample_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [SMP-1:0]   sample_ff;
   logic [ENV-1:0]          level_ff;
   logic [SB-1:0]           stage_ff;
   logic                    last_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign pop = adv && !empty;

   assign phase1 = head_data[ENTRY_BITS-1 -: PHASE_BITS];
   assign phase2 = {phase1[PHASE_BITS-2:0], 1'b0};
   assign phase3 = phase1 + phase2;

   assign tag_head.valid = !empty;
   assign tag_head.level = head_data[ahsv_pkg::ENTRY_EXTRA_BITS-1 -: ENV];
   assign tag_head.stage = head_data[SB:1];
   assign tag_head.last  = head_data[0];

   ahsv_sine_rom #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_rom1 (
      .clock  (clock),
      .enable (adv),
      .addr   (phase1[PHASE_BITS-1 -: SINE_ADDR_BITS]),
      .data   (sine1)
   );

   ahsv_sine_rom #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_rom2 (
      .clock  (clock),
      .enable (adv),
      .addr   (phase2[PHASE_BITS-1 -: SINE_ADDR_BITS]),
      .data   (sine2)
   );

   ahsv_sine_rom #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_rom3 (
      .clock  (clock),
      .enable (adv),
      .addr   (phase3[PHASE_BITS-1 -: SINE_ADDR_BITS]),
      .data   (sine3)
   );

   assign sine1_c_in = sine1;
   assign prod2_c_in = $signed({1'b0, mix_cfg.harmonic2_gain}) * sine2;
   assign prod3_c_in = $signed({1'b0, mix_cfg.harmonic3_gain}) * sine3;

   assign mix_sum  = $signed({{3{sine1_c_ff[SMP-1]}}, sine1_c_ff, 15'b0}) +
                     $signed({prod2_c_ff[32], prod2_c_ff}) +
                     $signed({prod3_c_ff[32], prod3_c_ff});
   assign mix_neg  = 34'(-mix_sum);
   assign neg_d_in = mix_sum[33];
   assign mag_d_in = mix_sum[33] ? mix_neg[32:0] : mix_sum[32:0];

   assign gain_prod  = {17'b0, mag_d_ff} * {33'b0, mix_cfg.output_gain};
   assign gain_round = gain_prod + 50'd32768;
   assign gmag_e_in  = gain_round[49:16];

   assign env_prod  = {26'b0, gmag_e_ff} * {35'b0, tag_e_ff.level};
   assign env_round = env_prod + (60'd1 << 38);
   assign final_mag = env_round[59:39];

   always_comb begin
      if (neg_e_ff) begin
         sample_in = (final_mag > 21'd32768) ? -16'sd32768 : 16'(-final_mag);
      end else begin
         sample_in = (final_mag > 21'd32767) ? 16'sd32767 : 16'(final_mag);
      end
   end

   assign rsp_valid_in = adv ? tag_e_ff.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sine1_c_ff     <= sine1_c_in;
         prod2_c_ff     <= prod2_c_in;
         prod3_c_ff     <= prod3_c_in;
         mag_d_ff       <= mag_d_in;
         neg_d_ff       <= neg_d_in;
         gmag_e_ff      <= gmag_e_in;
         neg_e_ff       <= neg_d_ff;
         sample_ff      <= sample_in;
         level_ff       <= tag_e_ff.level;
         stage_ff       <= tag_e_ff.stage;
         last_ff        <= tag_e_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_b_ff.valid <= 1'b0;
         tag_c_ff.valid <= 1'b0;
         tag_d_ff.valid <= 1'b0;
         tag_e_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (adv) begin
            tag_b_ff <= tag_head;
            tag_c_ff <= tag_b_ff;
            tag_d_ff <= tag_c_ff;
            tag_e_ff <= tag_d_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = sample_ff;
   assign rsp_envelope_level = level_ff;
   assign rsp_stage_now      = stage_ff;
   assign rsp_block_last     = last_ff;

endmodule

`default_nettype wire

FILE: src/adsr_harmonic_sine_voice.sv
// ----------------------------------------------------------------------------
// adsr_harmonic_sine_voice
// Additive sine voice (fundamental plus second and third harmonic) shaped by
// a six-stage linear envelope, one audio sample per input transaction.
//
// The req channel carries one sample tick per transaction: gate, fade
// request, phase step and block-end mark. The rsp channel returns one
// transaction per tick: the saturated sample, the envelope level and stage
// after the tick, and the block-end mark. Both use valid and stall.
// The front runs the envelope and phase recurrence once per tick and pushes
// into a four-entry queue. The back is a five-stage datapath (sine table
// read, harmonic products, sum and magnitude, gain, envelope scaling with
// saturation) ending in the output register; it sustains one tick per cycle
// while rsp_stall stays low. When rsp_stall is high with a valid result, the
// back holds every stage, the queue fills and req_stall rises once four
// ticks wait. Reset clears the phase, the envelope (level zero, stage idle),
// the queue and the pipeline, and loads the register defaults. The user must
// write registers over the csr port while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_harmonic_sine_voice #(
   parameter int PHASE_BITS     = ahsv_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_ADDR_BITS = ahsv_pkg::SINE_ADDR_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_note_on,
   input  wire logic                                  req_fade_start,
   input  wire logic [ahsv_pkg::STEP_BITS-1:0]        req_phase_step,
   input  wire logic                                  req_block_end,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [ahsv_pkg::SAMPLE_BITS-1:0]    rsp_sample_out,
   output logic [ahsv_pkg::ENV_BITS-1:0]              rsp_envelope_level,
   output logic [ahsv_pkg::STAGE_BITS-1:0]            rsp_stage_now,
   output logic                                       rsp_block_last,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [ahsv_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [ahsv_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [ahsv_pkg::CSR_DATA_BITS-1:0]         csr_prdata,
   output logic                                       csr_pready
);

   localparam int ENTRY_BITS = PHASE_BITS + ahsv_pkg::ENTRY_EXTRA_BITS;
   localparam int ENV        = ahsv_pkg::ENV_BITS;

   logic [16:0]     output_gain_ff;
   logic [15:0]     harmonic2_gain_ff;
   logic [15:0]     harmonic3_gain_ff;
   logic [ENV-1:0]  attack_step_ff;
   logic [ENV-1:0]  decay_step_ff;
   logic [ENV-1:0]  sustain_level_ff;
   logic [ENV-1:0]  release_step_ff;
   logic [ENV-1:0]  fade_step_ff;

   ahsv_pkg::reg_index_type  csr_index;
   logic                     csr_write;
   ahsv_pkg::env_cfg_type    env_cfg;
   ahsv_pkg::mix_cfg_type    mix_cfg;

   logic                     push;
   logic [ENTRY_BITS-1:0]    push_data;
   logic                     queue_full;
   logic                     pop;
   logic [ENTRY_BITS-1:0]    head_data;
   logic                     queue_empty;

   assign csr_pready = 1'b1;
   assign csr_index  = ahsv_pkg::reg_index_type'(csr_paddr[ahsv_pkg::CSR_ADDR_BITS-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_gain_ff    <= ahsv_pkg::OUTPUT_GAIN_RESET;
         harmonic2_gain_ff <= ahsv_pkg::HARMONIC2_GAIN_RESET;
         harmonic3_gain_ff <= ahsv_pkg::HARMONIC3_GAIN_RESET;
         attack_step_ff    <= ahsv_pkg::ATTACK_STEP_RESET;
         decay_step_ff     <= ahsv_pkg::DECAY_STEP_RESET;
         sustain_level_ff  <= ahsv_pkg::SUSTAIN_LEVEL_RESET;
         release_step_ff   <= ahsv_pkg::RELEASE_STEP_RESET;
         fade_step_ff      <= ahsv_pkg::FADE_STEP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ahsv_pkg::REG_OUTPUT_GAIN:    output_gain_ff    <= csr_pwdata[16:0];
            ahsv_pkg::REG_HARMONIC2_GAIN: harmonic2_gain_ff <= csr_pwdata[15:0];
            ahsv_pkg::REG_HARMONIC3_GAIN: harmonic3_gain_ff <= csr_pwdata[15:0];
            ahsv_pkg::REG_ATTACK_STEP:    attack_step_ff    <= csr_pwdata[ENV-1:0];
            ahsv_pkg::REG_DECAY_STEP:     decay_step_ff     <= csr_pwdata[ENV-1:0];
            ahsv_pkg::REG_SUSTAIN_LEVEL:  sustain_level_ff  <= csr_pwdata[ENV-1:0];
            ahsv_pkg::REG_RELEASE_STEP:   release_step_ff   <= csr_pwdata[ENV-1:0];
            ahsv_pkg::REG_FADE_STEP:      fade_step_ff      <= csr_pwdata[ENV-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ahsv_pkg::REG_OUTPUT_GAIN:    csr_prdata = 32'(output_gain_ff);
         ahsv_pkg::REG_HARMONIC2_GAIN: csr_prdata = 32'(harmonic2_gain_ff);
         ahsv_pkg::REG_HARMONIC3_GAIN: csr_prdata = 32'(harmonic3_gain_ff);
         ahsv_pkg::REG_ATTACK_STEP:    csr_prdata = 32'(attack_step_ff);
         ahsv_pkg::REG_DECAY_STEP:     csr_prdata = 32'(decay_step_ff);
         ahsv_pkg::REG_SUSTAIN_LEVEL:  csr_prdata = 32'(sustain_level_ff);
         ahsv_pkg::REG_RELEASE_STEP:   csr_prdata = 32'(release_step_ff);
         ahsv_pkg::REG_FADE_STEP:      csr_prdata = 32'(fade_step_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   assign env_cfg.attack_step   = attack_step_ff;
   assign env_cfg.decay_step    = decay_step_ff;
   assign env_cfg.sustain_level = sustain_level_ff;
   assign env_cfg.release_step  = release_step_ff;
   assign env_cfg.fade_step     = fade_step_ff;

   assign mix_cfg.output_gain    = output_gain_ff;
   assign mix_cfg.harmonic2_gain = harmonic2_gain_ff;
   assign mix_cfg.harmonic3_gain = harmonic3_gain_ff;

   ahsv_front #(.PHASE_BITS(PHASE_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_note_on    (req_note_on),
      .req_fade_start (req_fade_start),
      .req_phase_step (req_phase_step),
      .req_block_end  (req_block_end),
      .env_cfg        (env_cfg),
      .queue_full     (queue_full),
      .push           (push),
      .push_data      (push_data)
   );

   ahsv_queue #(.ENTRY_BITS(ENTRY_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head_data (head_data),
      .empty     (queue_empty)
   );

   ahsv_back #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_data          (head_data),
      .empty              (queue_empty),
      .pop                (pop),
      .mix_cfg            (mix_cfg),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_envelope_level (rsp_envelope_level),
      .rsp_stage_now      (rsp_stage_now),
      .rsp_block_last     (rsp_block_last)
   );

endmodule

`default_nettype wire

FILE: dv/tb_adsr_harmonic_sine_voice.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adsr_harmonic_sine_voice
// Self-checking bench for the harmonic sine voice. A directed list of ticks
// and register writes walks the envelope through every stage and the gain,
// step and sustain extremes. Random phases follow, each with new register
// settings and gated note sequences. Every result transaction is compared
// with a bit-true model of the envelope, phase and sine mix or a typed value.
// ----------------------------------------------------------------------------

module tb_adsr_harmonic_sine_voice;

   localparam int SAMPLE_BITS   = ahsv_pkg::SAMPLE_BITS;
   localparam int ENV_BITS      = ahsv_pkg::ENV_BITS;
   localparam int STAGE_BITS    = ahsv_pkg::STAGE_BITS;
   localparam int STEP_BITS     = ahsv_pkg::STEP_BITS;
   localparam int CSR_ADDR_BITS = ahsv_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = ahsv_pkg::CSR_DATA_BITS;
   localparam int ADDR_BITS     = ahsv_pkg::SINE_ADDR_BITS_DEFAULT;
   localparam int QUARTER_BITS  = ADDR_BITS - 2;
   localparam logic [ENV_BITS-1:0] FULL_SCALE = ahsv_pkg::FULL_SCALE;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [ENV_BITS-1:0]           level;
      logic [STAGE_BITS-1:0]         stage;
      logic                          last;
   } voice_result_type;

   typedef struct {
      bit                       is_write;
      ahsv_pkg::reg_index_type  idx;
      bit [31:0]                value;
      bit                       note;
      bit                       fade;
      bit [30:0]                step;
      bit                       last;
      bit                       typed;
      voice_result_type         want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_note_on = 1'b0;
   logic                      req_fade_start = 1'b0;
   logic [STEP_BITS-1:0]      req_phase_step = '0;
   logic                      req_block_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic [ENV_BITS-1:0]       rsp_envelope_level;
   logic [STAGE_BITS-1:0]     rsp_stage_now;
   logic                      rsp_block_last;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   adsr_harmonic_sine_voice dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_note_on        (req_note_on),
      .req_fade_start     (req_fade_start),
      .req_phase_step     (req_phase_step),
      .req_block_end      (req_block_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_envelope_level (rsp_envelope_level),
      .rsp_stage_now      (rsp_stage_now),
      .rsp_block_last     (rsp_block_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Voice model state and register copies.
   bit [16:0]         gain_out  = ahsv_pkg::OUTPUT_GAIN_RESET;
   bit [15:0]         gain_h2   = ahsv_pkg::HARMONIC2_GAIN_RESET;
   bit [15:0]         gain_h3   = ahsv_pkg::HARMONIC3_GAIN_RESET;
   bit [ENV_BITS-1:0] rate_atk  = ahsv_pkg::ATTACK_STEP_RESET;
   bit [ENV_BITS-1:0] rate_dec  = ahsv_pkg::DECAY_STEP_RESET;
   bit [ENV_BITS-1:0] hold_sus  = ahsv_pkg::SUSTAIN_LEVEL_RESET;
   bit [ENV_BITS-1:0] rate_rel  = ahsv_pkg::RELEASE_STEP_RESET;
   bit [ENV_BITS-1:0] rate_fade = ahsv_pkg::FADE_STEP_RESET;
   bit [31:0]         voice_phase = '0;
   bit [ENV_BITS-1:0] voice_level = '0;
   ahsv_pkg::stage_type voice_stage = ahsv_pkg::STAGE_IDLE;

   voice_result_type expected_voice[$];
   plan_row_type     plan_rows[$];
   int               mismatch_count = 0;
   int               ticks_sent = 0;
   int               results_seen = 0;

   function automatic longint quarter_sine_q15(input longint unsigned q);
      longint unsigned x, s, t, r;
      x = (q * HALF_PI_Q30 + ((64'd1 << QUARTER_BITS) >> 1)) >> QUARTER_BITS;
      s = (x * x) >> 30;
      t = ONE_Q30 - s / 72;
      t = ONE_Q30 - ((s * t) >> 30) / 42;
      t = ONE_Q30 - ((s * t) >> 30) / 20;
      t = ONE_Q30 - ((s * t) >> 30) / 6;
      r = (x * t) >> 30;
      return longint'((r * 32767 + (64'd1 << 29)) >> 30);
   endfunction

   function automatic longint sine_at_phase(input bit [31:0] ph);
      bit [ADDR_BITS-1:0] addr;
      bit [1:0] quad;
      longint unsigned offs;
      longint v;
      addr = ph[31 -: ADDR_BITS];
      quad = addr[ADDR_BITS-1 -: 2];
      offs = addr[QUARTER_BITS-1:0];
      v = quad[0] ? quarter_sine_q15((64'd1 << QUARTER_BITS) - offs) : quarter_sine_q15(offs);
      return quad[1] ? -v : v;
   endfunction

   function automatic void drop_level(input bit [ENV_BITS-1:0] rate,
                                      input bit [ENV_BITS-1:0] floor_level,
                                      input ahsv_pkg::stage_type next_stage);
      longint e;
      e = longint'({39'd0, voice_level}) - longint'({39'd0, rate});
      if (e <= longint'({39'd0, floor_level})) begin
         voice_level = floor_level;
         voice_stage = next_stage;
      end else begin
         voice_level = e[ENV_BITS-1:0];
      end
   endfunction

   function automatic voice_result_type predict_voice_tick(input bit note, input bit fade,
                                                           input bit [30:0] step,
                                                           input bit last);
      voice_result_type res;
      longint unsigned sum, m;
      longint s1, s2, s3, w, h2v, h3v, smp;
      bit [31:0] ph2, ph3;
      bit neg;
      if (fade) voice_stage = ahsv_pkg::STAGE_FADE;
      if (voice_stage == ahsv_pkg::STAGE_FADE) begin
         drop_level(rate_fade, '0, ahsv_pkg::STAGE_IDLE);
      end else begin
         if (note && voice_stage == ahsv_pkg::STAGE_IDLE) voice_stage = ahsv_pkg::STAGE_ATTACK;
         if (!note && voice_stage != ahsv_pkg::STAGE_IDLE &&
             voice_stage != ahsv_pkg::STAGE_RELEASE)
            voice_stage = ahsv_pkg::STAGE_RELEASE;
         case (voice_stage)
            ahsv_pkg::STAGE_ATTACK: begin
               sum = {39'd0, voice_level} + {39'd0, rate_atk};
               if (sum >= {39'd0, FULL_SCALE}) begin
                  voice_level = FULL_SCALE;
                  voice_stage = ahsv_pkg::STAGE_DECAY;
               end else begin
                  voice_level = sum[ENV_BITS-1:0];
               end
            end
            ahsv_pkg::STAGE_DECAY:   drop_level(rate_dec, hold_sus, ahsv_pkg::STAGE_SUSTAIN);
            ahsv_pkg::STAGE_SUSTAIN: voice_level = hold_sus;
            ahsv_pkg::STAGE_RELEASE: drop_level(rate_rel, '0, ahsv_pkg::STAGE_IDLE);
            default: ;
         endcase
      end
      ph2 = voice_phase << 1;
      ph3 = voice_phase + (voice_phase << 1);
      s1 = sine_at_phase(voice_phase);
      s2 = sine_at_phase(ph2);
      s3 = sine_at_phase(ph3);
      h2v = {48'd0, gain_h2};
      h3v = {48'd0, gain_h3};
      w = s1 * 32768 + h2v * s2 + h3v * s3;
      neg = (w < 0);
      m = neg ? longint'(-w) : longint'(w);
      m = (m * {47'd0, gain_out} + 64'd32768) >> 16;
      m = (m * {39'd0, voice_level} + (64'd1 << 38)) >> 39;
      if (neg) smp = (m > 32768) ? -32768 : -longint'(m);
      else smp = (m > 32767) ? 32767 : longint'(m);
      voice_phase = voice_phase + {1'b0, step};
      res.sample = smp[SAMPLE_BITS-1:0];
      res.level  = voice_level;
      res.stage  = voice_stage;
      res.last   = last;
      return res;
   endfunction

   function automatic void add_write(input ahsv_pkg::reg_index_type idx, input bit [31:0] value);
      plan_row_type row;
      row.is_write = 1'b1;
      row.idx = idx;
      row.value = value;
      row.note = 1'b0;
      row.fade = 1'b0;
      row.step = '0;
      row.last = 1'b0;
      row.typed = 1'b0;
      row.want = '0;
      plan_rows.push_back(row);
   endfunction

   function automatic void add_tick(input bit note, input bit fade, input bit [30:0] step,
                                    input bit last, input bit typed = 1'b0,
                                    input bit [ENV_BITS-1:0] lvl = '0,
                                    input ahsv_pkg::stage_type stg = ahsv_pkg::STAGE_IDLE);
      plan_row_type row;
      row.is_write = 1'b0;
      row.idx = ahsv_pkg::REG_OUTPUT_GAIN;
      row.value = '0;
      row.note = note;
      row.fade = fade;
      row.step = step;
      row.last = last;
      row.typed = typed;
      row.want.sample = '0;
      row.want.level = lvl;
      row.want.stage = stg;
      row.want.last = last;
      plan_rows.push_back(row);
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_voice.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input ahsv_pkg::reg_index_type idx, input bit [31:0] value);
      bit ready;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ready = csr_pready;
         @(posedge clock);
      end while (!ready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         ahsv_pkg::REG_OUTPUT_GAIN:    gain_out  = value[16:0];
         ahsv_pkg::REG_HARMONIC2_GAIN: gain_h2   = value[15:0];
         ahsv_pkg::REG_HARMONIC3_GAIN: gain_h3   = value[15:0];
         ahsv_pkg::REG_ATTACK_STEP:    rate_atk  = value[ENV_BITS-1:0];
         ahsv_pkg::REG_DECAY_STEP:     rate_dec  = value[ENV_BITS-1:0];
         ahsv_pkg::REG_SUSTAIN_LEVEL:  hold_sus  = value[ENV_BITS-1:0];
         ahsv_pkg::REG_RELEASE_STEP:   rate_rel  = value[ENV_BITS-1:0];
         ahsv_pkg::REG_FADE_STEP:      rate_fade = value[ENV_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_tick(input bit note, input bit fade, input bit [30:0] step,
                            input bit last, input bit typed, input voice_result_type want);
      voice_result_type predicted;
      bit taken;
      while (!(ticks_sent >= 200 && ticks_sent < 300) && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_note_on <= note;
      req_fade_start <= fade;
      req_phase_step <= step;
      req_block_end <= last;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predicted = predict_voice_tick(note, fade, step, last);
      expected_voice.push_back(typed ? want : predicted);
      ticks_sent++;
   endtask

   function automatic bit [31:0] pick_rate();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'h01FF_FFFF;
         2: return 32'd1;
         3: return {7'd0, FULL_SCALE};
         default: return $urandom_range(1 << 18, 1 << 22);
      endcase
   endfunction

   function automatic bit [31:0] pick_harmonic();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'h0000_FFFF;
         default: return $urandom_range(0, 32768);
      endcase
   endfunction

   // Result side: sample at the falling edge, commit at the rising edge.
   initial begin : result_side
      voice_result_type got, want;
      bit took;
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         took = !reset && (rsp_valid === 1'b1) && !rsp_stall;
         got.sample = rsp_sample_out;
         got.level  = rsp_envelope_level;
         got.stage  = rsp_stage_now;
         got.last   = rsp_block_last;
         @(posedge clock);
         if (took) begin
            results_seen++;
            if (expected_voice.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected transaction: sample %0d level %0d stage %0d last %0b",
                           got.sample, got.level, got.stage, got.last);
            end else begin
               want = expected_voice.pop_front();
               if (got.sample !== want.sample || got.level !== want.level ||
                   got.stage !== want.stage || got.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"Mismatch at transaction %0d: sample %0d/%0d level %0d/%0d ",
                               "stage %0d/%0d last %0b/%0b (expected/actual)"},
                              results_seen, want.sample, got.sample, want.level, got.level,
                              want.stage, got.stage, want.last, got.last);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_seen == 40) begin
            hold_done = 1'b1;
            hold_left = 80;
            rsp_stall <= 1'b1;
         end else if (results_seen >= 200 && results_seen < 300) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 35);
         end
      end
   end

   initial begin : stimulus
      voice_result_type none;
      bit note, fade, last;
      bit [30:0] step;
      int gate_left;
      none = '0;

      add_tick(1'b0, 1'b0, 31'd0, 1'b0, 1'b1, '0, ahsv_pkg::STAGE_IDLE);
      add_tick(1'b0, 1'b1, 31'h7FFF_FFFF, 1'b1, 1'b1, '0, ahsv_pkg::STAGE_IDLE);
      add_tick(1'b1, 1'b0, 31'h4000_0000, 1'b0);
      add_tick(1'b1, 1'b0, 31'd0, 1'b1);
      add_write(ahsv_pkg::REG_ATTACK_STEP, 32'h01FF_FFFF);
      add_write(ahsv_pkg::REG_OUTPUT_GAIN, 32'h0001_FFFF);
      add_write(ahsv_pkg::REG_HARMONIC2_GAIN, 32'h0000_FFFF);
      add_write(ahsv_pkg::REG_HARMONIC3_GAIN, 32'h0000_FFFF);
      add_tick(1'b1, 1'b0, 31'h1555_5555, 1'b0);
      add_tick(1'b1, 1'b0, 31'h0AAA_AAAA, 1'b0);
      add_write(ahsv_pkg::REG_DECAY_STEP, 32'd0);
      add_tick(1'b1, 1'b0, 31'h1234_5678, 1'b0);
      add_tick(1'b1, 1'b0, 31'h7FFF_FFFF, 1'b1);
      add_write(ahsv_pkg::REG_SUSTAIN_LEVEL, 32'h01FF_FFFF);
      add_write(ahsv_pkg::REG_DECAY_STEP, 32'd1);
      add_tick(1'b1, 1'b0, 31'h2000_0000, 1'b0);
      add_tick(1'b1, 1'b0, 31'h2000_0000, 1'b0);
      add_write(ahsv_pkg::REG_RELEASE_STEP, 32'd0);
      add_tick(1'b0, 1'b0, 31'h0C00_0000, 1'b0);
      add_tick(1'b0, 1'b0, 31'h0C00_0000, 1'b1);
      add_write(ahsv_pkg::REG_RELEASE_STEP, 32'h01FF_FFFF);
      add_tick(1'b0, 1'b0, 31'd0, 1'b0, 1'b1, '0, ahsv_pkg::STAGE_IDLE);
      add_tick(1'b1, 1'b0, 31'h0100_0000, 1'b0);
      add_tick(1'b1, 1'b1, 31'h0100_0000, 1'b0);
      add_write(ahsv_pkg::REG_FADE_STEP, 32'd0);
      add_tick(1'b1, 1'b0, 31'h0100_0000, 1'b0);
      add_tick(1'b0, 1'b1, 31'h0100_0000, 1'b0);
      add_write(ahsv_pkg::REG_FADE_STEP, 32'h01FF_FFFF);
      add_tick(1'b0, 1'b0, 31'd0, 1'b1, 1'b1, '0, ahsv_pkg::STAGE_IDLE);
      add_write(ahsv_pkg::REG_OUTPUT_GAIN, 32'd0);
      add_tick(1'b1, 1'b0, 31'h0555_5555, 1'b0, 1'b1, FULL_SCALE, ahsv_pkg::STAGE_DECAY);
      add_tick(1'b1, 1'b0, 31'h0555_5555, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan_rows[i]) begin
         if (plan_rows[i].is_write) begin
            wait_drained();
            write_register(plan_rows[i].idx, plan_rows[i].value);
         end else begin
            send_tick(plan_rows[i].note, plan_rows[i].fade, plan_rows[i].step,
                      plan_rows[i].last, plan_rows[i].typed, plan_rows[i].want);
         end
      end

      note = 1'b0;
      gate_left = 0;
      for (int phase_no = 0; phase_no < 8; phase_no++) begin
         wait_drained();
         write_register(ahsv_pkg::REG_OUTPUT_GAIN,
                        ($urandom_range(7) == 0) ? 32'h0001_FFFF : $urandom_range(0, 65536));
         write_register(ahsv_pkg::REG_HARMONIC2_GAIN, pick_harmonic());
         write_register(ahsv_pkg::REG_HARMONIC3_GAIN, pick_harmonic());
         write_register(ahsv_pkg::REG_ATTACK_STEP, pick_rate());
         write_register(ahsv_pkg::REG_DECAY_STEP, pick_rate());
         write_register(ahsv_pkg::REG_SUSTAIN_LEVEL,
                        ($urandom_range(7) == 0) ? 32'h01FF_FFFF : $urandom_range(0, 1 << 24));
         write_register(ahsv_pkg::REG_RELEASE_STEP, pick_rate());
         write_register(ahsv_pkg::REG_FADE_STEP, pick_rate());
         for (int k = 0; k < 50; k++) begin
            if (gate_left == 0) begin
               note = !note;
               gate_left = note ? $urandom_range(1, 48) : $urandom_range(1, 24);
            end
            gate_left--;
            fade = ($urandom_range(24) == 0);
            last = ($urandom_range(7) == 0);
            case ($urandom_range(7))
               0: step = 31'd0;
               1: step = 31'h7FFF_FFFF;
               2: step = 31'($urandom_range(0, 1 << 16));
               default: step = 31'($urandom);
            endcase
            send_tick(($urandom_range(9) == 0) ? ($urandom_range(1) == 1) : note,
                      fade, step, last, 1'b0, none);
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_voice.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: adsr_harmonic_sine_voice.f
src/ahsv_pkg.sv
src/ahsv_front.sv
src/ahsv_queue.sv
src/ahsv_sine_rom.sv
src/ahsv_back.sv
src/adsr_harmonic_sine_voice.sv
dv/tb_adsr_harmonic_sine_voice.sv
